/* hdl/replay_clock_update_assert.svh */
// ----------------------------------------------------------------------------
// Replay clock update: assertion macros
// Concurrent check macros for the replay clock top level; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef REPLAY_CLOCK_UPDATE_ASSERT_SVH
`define REPLAY_CLOCK_UPDATE_ASSERT_SVH
`ifndef SYNTH
`define RCU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("replay clock check failed");
`define RCU_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("replay clock reset check failed");
`else
`define RCU_ASSERT(lbl, clk, rst, prop)
`define RCU_ASSERT_RST(lbl, clk, prop)
`endif
`endif

/* hdl/rcu_pkg.sv */
// ----------------------------------------------------------------------------
// Replay clock update package
// Payload types, register indexes and default sizes of the replay clock.
// ----------------------------------------------------------------------------
package rcu_pkg;

  localparam int NUM_PROCS_DEF   = 4;
  localparam int OFFSET_BITS_DEF = 16;

  localparam int TIME_W  = 32;
  localparam int VALID_W = 4;
  localparam int WORD_W  = 64;
  localparam int COUNT_W = 16;
  localparam int EPS_W   = 16;
  localparam int OWN_W   = 2;
  localparam int CFG_W   = 16;

  localparam logic [EPS_W-1:0]   EPSILON_RESET = '1;
  localparam logic [OWN_W-1:0]   OWN_RESET     = '0;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

  typedef enum logic [0:0] {
    REG_EPSILON     = 1'b0,
    REG_OWN_PROCESS = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    CMD_SEND    = 1'b0,
    CMD_RECEIVE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [0:0]         cmd;
    logic [TIME_W-1:0]  phys_time;
    logic [TIME_W-1:0]  msg_time;
    logic [VALID_W-1:0] msg_valid;
    logic [WORD_W-1:0]  msg_offset_word;
    logic [COUNT_W-1:0] msg_count;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  clock_time;
    logic [VALID_W-1:0] clock_valid;
    logic [WORD_W-1:0]  clock_offset_word;
    logic [COUNT_W-1:0] clock_count;
  } result_t;

endpackage

/* hdl/rcu_cfg.sv */
// ----------------------------------------------------------------------------
// Replay clock configuration registers
// Holds epsilon and the own process index and derives the effective bound.
// ----------------------------------------------------------------------------
module rcu_cfg #(
  parameter int NUM_PROCS   = rcu_pkg::NUM_PROCS_DEF,
  parameter int OFFSET_BITS = rcu_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  rcu_pkg::cfg_reg_t              cfg_index,
  input  logic [rcu_pkg::CFG_W-1:0]      cfg_data,
  output logic [OFFSET_BITS-1:0]         eff_eps,
  output logic [$clog2(NUM_PROCS)-1:0]   own_idx
);

  localparam int PW  = $clog2(NUM_PROCS);
  localparam int EW  = (OFFSET_BITS > rcu_pkg::EPS_W) ? OFFSET_BITS : rcu_pkg::EPS_W;
  localparam int OW0 = $clog2(NUM_PROCS + 1);
  localparam int OW  = (OW0 > rcu_pkg::OWN_W) ? OW0 : rcu_pkg::OWN_W;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  logic [rcu_pkg::EPS_W-1:0] epsilon;
  logic [rcu_pkg::OWN_W-1:0] own_process;
  logic [OW-1:0]             own_wide;
  logic [OW-1:0]             own_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon     <= rcu_pkg::EPSILON_RESET;
      own_process <= rcu_pkg::OWN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcu_pkg::REG_EPSILON:     epsilon     <= cfg_data[rcu_pkg::EPS_W-1:0];
        rcu_pkg::REG_OWN_PROCESS: own_process <= cfg_data[rcu_pkg::OWN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (EW'(epsilon) > EW'(OFF_MAX)) begin
      eff_eps = OFF_MAX;
    end else begin
      eff_eps = OFFSET_BITS'(epsilon);
    end
    own_wide = OW'(own_process);
    if (own_wide >= OW'(NUM_PROCS)) begin
      own_wrap = own_wide - OW'(NUM_PROCS);
    end else begin
      own_wrap = own_wide;
    end
    own_idx = PW'(own_wrap);
  end

endmodule

/* hdl/rcu_update.sv */
// ----------------------------------------------------------------------------
// Replay clock next-state logic
// Computes the clock after one send, local or receive event.
// ----------------------------------------------------------------------------
module rcu_update #(
  parameter int NUM_PROCS   = rcu_pkg::NUM_PROCS_DEF,
  parameter int OFFSET_BITS = rcu_pkg::OFFSET_BITS_DEF
) (
  input  rcu_pkg::item_t                              item,
  input  logic [OFFSET_BITS-1:0]                      eff_eps,
  input  logic [$clog2(NUM_PROCS)-1:0]                own_idx,
  input  logic [rcu_pkg::TIME_W-1:0]                  logical_time,
  input  logic [NUM_PROCS-1:0]                        proc_valid,
  input  logic [NUM_PROCS-1:0][OFFSET_BITS-1:0]       proc_offset,
  input  logic [rcu_pkg::COUNT_W-1:0]                 event_count,
  output logic [rcu_pkg::TIME_W-1:0]                  logical_time_next,
  output logic [NUM_PROCS-1:0]                        proc_valid_next,
  output logic [NUM_PROCS-1:0][OFFSET_BITS-1:0]       proc_offset_next,
  output logic [rcu_pkg::COUNT_W-1:0]                 event_count_next
);

  localparam int TW  = rcu_pkg::TIME_W;
  localparam int SW  = TW + 1;
  localparam int MW  = (NUM_PROCS > rcu_pkg::VALID_W) ? NUM_PROCS : rcu_pkg::VALID_W;
  localparam int WW0 = NUM_PROCS * OFFSET_BITS;
  localparam int WW  = (WW0 > rcu_pkg::WORD_W) ? WW0 : rcu_pkg::WORD_W;

  logic [TW-1:0]                          t_lm;
  logic [TW-1:0]                          nt_rcv;
  logic [TW-1:0]                          nt_send;
  logic [TW-1:0]                          nt;
  logic [TW-1:0]                          dn;
  logic [TW-1:0]                          dm;
  logic [TW-1:0]                          want;
  logic [MW-1:0]                          mv_ext;
  logic [NUM_PROCS-1:0]                   mv;
  logic [WW-1:0]                          mword_ext;
  logic [NUM_PROCS-1:0][OFFSET_BITS-1:0]  slot;
  logic [NUM_PROCS-1:0][SW-1:0]           a_sum;
  logic [NUM_PROCS-1:0][SW-1:0]           b_sum;
  logic [NUM_PROCS-1:0][OFFSET_BITS-1:0]  a_off;
  logic [NUM_PROCS-1:0][OFFSET_BITS-1:0]  b_off;
  logic [NUM_PROCS-1:0][OFFSET_BITS-1:0]  m_off;
  logic [NUM_PROCS-1:0][OFFSET_BITS-1:0]  new_off;
  logic [NUM_PROCS-1:0]                   new_valid;
  logic [NUM_PROCS-1:0][OFFSET_BITS-1:0]  sh_off;
  logic [NUM_PROCS-1:0]                   sh_valid;
  logic [NUM_PROCS-1:0]                   node_miss;
  logic [NUM_PROCS-1:0]                   msg_miss;
  logic [SW-1:0]                          eps_w;
  logic [OFFSET_BITS-1:0]                 own_off;
  logic                                   node_eq;
  logic                                   msg_eq;
  logic [rcu_pkg::COUNT_W-1:0]            cnt_max;
  logic [rcu_pkg::COUNT_W-1:0]            inc_base;
  logic [rcu_pkg::COUNT_W-1:0]            rcv_count;
  logic [rcu_pkg::COUNT_W-1:0]            send_inc;

  always_comb begin
    eps_w   = SW'(eff_eps);
    t_lm    = (logical_time > item.msg_time) ? logical_time : item.msg_time;
    nt_rcv  = (item.phys_time > t_lm) ? item.phys_time : t_lm;
    nt_send = (logical_time > item.phys_time) ? logical_time : item.phys_time;
    nt      = (item.cmd == rcu_pkg::CMD_RECEIVE) ? nt_rcv : nt_send;
    dn      = nt - logical_time;
    dm      = nt - item.msg_time;
    want    = nt_send - item.phys_time;

    mv_ext    = MW'(item.msg_valid);
    mv        = mv_ext[NUM_PROCS-1:0];
    mword_ext = WW'(item.msg_offset_word);

    for (int p = 0; p < NUM_PROCS; p++) begin
      slot[p]  = mword_ext[p*OFFSET_BITS +: OFFSET_BITS];
      a_sum[p] = SW'(dn) + SW'(proc_offset[p]);
      b_sum[p] = SW'(dm) + SW'(slot[p]);
      a_off[p] = (proc_valid[p] && (a_sum[p] < eps_w)) ?
                 a_sum[p][OFFSET_BITS-1:0] : eff_eps;
      b_off[p] = (mv[p] && (b_sum[p] < eps_w)) ? b_sum[p][OFFSET_BITS-1:0] : eff_eps;
      m_off[p] = (a_off[p] < b_off[p]) ? a_off[p] : b_off[p];
      new_valid[p] = (m_off[p] < eff_eps);
      new_off[p]   = new_valid[p] ? m_off[p] : '0;
      sh_valid[p]  = proc_valid[p] && (a_sum[p] < eps_w);
      sh_off[p]    = sh_valid[p] ? a_sum[p][OFFSET_BITS-1:0] : '0;
      node_miss[p] = new_valid[p] && (proc_offset[p] != new_off[p]);
      msg_miss[p]  = new_valid[p] && (slot[p] != new_off[p]);
    end

    node_eq = (logical_time == nt) && (proc_valid == new_valid) && !(|node_miss);
    msg_eq  = (item.msg_time == nt) && (mv == new_valid) && !(|msg_miss);
    cnt_max = (event_count > item.msg_count) ? event_count : item.msg_count;
    inc_base = node_eq ? (msg_eq ? cnt_max : event_count) : item.msg_count;
    if (!node_eq && !msg_eq) begin
      rcv_count = '0;
    end else if (inc_base == rcu_pkg::COUNT_MAX) begin
      rcv_count = rcu_pkg::COUNT_MAX;
    end else begin
      rcv_count = inc_base + 1'b1;
    end
    send_inc = (event_count == rcu_pkg::COUNT_MAX) ? rcu_pkg::COUNT_MAX :
               event_count + 1'b1;

    own_off = (proc_valid[own_idx] && (proc_offset[own_idx] < eff_eps)) ?
              proc_offset[own_idx] : eff_eps;

    logical_time_next = nt;
    proc_valid_next   = proc_valid;
    proc_offset_next  = proc_offset;
    event_count_next  = '0;

    if (item.cmd == rcu_pkg::CMD_RECEIVE) begin
      proc_valid_next           = new_valid;
      proc_offset_next          = new_off;
      proc_valid_next[own_idx]  = 1'b1;
      proc_offset_next[own_idx] = '0;
      event_count_next          = rcv_count;
    end else if (nt_send == logical_time) begin
      if (SW'(own_off) <= SW'(want)) begin
        event_count_next = send_inc;
      end else begin
        proc_valid_next[own_idx]  = 1'b1;
        proc_offset_next[own_idx] = want[OFFSET_BITS-1:0];
      end
    end else begin
      proc_valid_next           = sh_valid;
      proc_offset_next          = sh_off;
      proc_valid_next[own_idx]  = 1'b1;
      proc_offset_next[own_idx] = '0;
    end
  end

endmodule

/* hdl/replay_clock_update.sv */
// ----------------------------------------------------------------------------
// Replay clock update
// One node's replay clock: logical time, per-process offsets and valid bits,
// and a saturating event counter, updated once for each transfer in.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the result side does not stall,
// and returns one result per item: the item lands in an input register, and
// the combinational clock update then writes the clock state, which is the
// result shown on the output port. Throughput is set by that one update
// stage, whose state feeds straight back into the next item. A stall on the
// result side holds the state and, one item later, stalls the input side.
// Registers are to be written by the user only while no item is in flight;
// the block does not enforce this. There is no clearing pass after reset.
module replay_clock_update #(
  parameter int NUM_PROCS   = rcu_pkg::NUM_PROCS_DEF,
  parameter int OFFSET_BITS = rcu_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  rcu_pkg::item_t               item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output rcu_pkg::result_t             result,
  input  logic                         cfg_we,
  input  rcu_pkg::cfg_reg_t            cfg_index,
  input  logic [rcu_pkg::CFG_W-1:0]    cfg_data
);

`include "replay_clock_update_assert.svh"

  localparam int PW  = $clog2(NUM_PROCS);
  localparam int WW0 = NUM_PROCS * OFFSET_BITS;
  localparam int WW  = (WW0 > rcu_pkg::WORD_W) ? WW0 : rcu_pkg::WORD_W;

  logic [OFFSET_BITS-1:0]                eff_eps;
  logic [PW-1:0]                         own_idx;
  rcu_pkg::item_t                        in_reg;
  logic                                  in_full;
  logic                                  adv;
  logic [rcu_pkg::TIME_W-1:0]            logical_time;
  logic [NUM_PROCS-1:0]                  proc_valid;
  logic [NUM_PROCS-1:0][OFFSET_BITS-1:0] proc_offset;
  logic [rcu_pkg::COUNT_W-1:0]           event_count;
  logic [rcu_pkg::TIME_W-1:0]            logical_time_next;
  logic [NUM_PROCS-1:0]                  proc_valid_next;
  logic [NUM_PROCS-1:0][OFFSET_BITS-1:0] proc_offset_next;
  logic [rcu_pkg::COUNT_W-1:0]           event_count_next;
  logic [WW-1:0]                         word_ext;

  rcu_cfg #(
    .NUM_PROCS   (NUM_PROCS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eff_eps   (eff_eps),
    .own_idx   (own_idx)
  );

  rcu_update #(
    .NUM_PROCS   (NUM_PROCS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_update (
    .item              (in_reg),
    .eff_eps           (eff_eps),
    .own_idx           (own_idx),
    .logical_time      (logical_time),
    .proc_valid        (proc_valid),
    .proc_offset       (proc_offset),
    .event_count       (event_count),
    .logical_time_next (logical_time_next),
    .proc_valid_next   (proc_valid_next),
    .proc_offset_next  (proc_offset_next),
    .event_count_next  (event_count_next)
  );

  assign adv        = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
      logical_time <= '0;
      proc_valid   <= '0;
      proc_offset  <= '0;
      event_count  <= '0;
    end else begin
      if (item_valid && !item_stall) begin
        in_full <= 1'b1;
        in_reg  <= item;
      end else if (adv) begin
        in_full <= 1'b0;
      end
      if (adv) begin
        result_valid <= 1'b1;
        logical_time <= logical_time_next;
        proc_valid   <= proc_valid_next;
        proc_offset  <= proc_offset_next;
        event_count  <= event_count_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    word_ext = '0;
    for (int p = 0; p < NUM_PROCS; p++) begin
      word_ext[p*OFFSET_BITS +: OFFSET_BITS] = proc_valid[p] ? proc_offset[p] : '0;
    end
    result.clock_time        = logical_time;
    result.clock_valid       = rcu_pkg::VALID_W'(proc_valid);
    result.clock_offset_word = word_ext[rcu_pkg::WORD_W-1:0];
    result.clock_count       = event_count;
  end

  `RCU_ASSERT_RST(a_reset_empty, clk, rst |=> !result_valid && !in_full)
  `RCU_ASSERT(a_update_shows, clk, rst, adv |=> result_valid)
  `RCU_ASSERT(a_receive_own_valid, clk, rst, adv && in_reg.cmd |=> proc_valid[$past(own_idx)])
  `RCU_ASSERT(a_move_clears_count, clk, rst, adv && !in_reg.cmd && (logical_time_next != logical_time) |=> event_count == '0)

endmodule

/* tb/tb_replay_clock_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay clock update testbench
// Drives send and receive events into the replay clock and keeps its own copy
// of the node clock. Each result transfer is checked field by field against
// the oldest predicted clock. Both sides idle and stall at random, and the
// epsilon and own-process registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_replay_clock_update;

  localparam int PROCS       = rcu_pkg::NUM_PROCS_DEF;
  localparam int OFF_W       = rcu_pkg::OFFSET_BITS_DEF;
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 200000;

  logic                           clk          = 1'b0;
  logic                           rst          = 1'b1;
  logic                           item_valid   = 1'b0;
  logic                           item_stall;
  rcu_pkg::item_t                 item         = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  rcu_pkg::result_t               result;
  logic                           cfg_we       = 1'b0;
  rcu_pkg::cfg_reg_t              cfg_index    = rcu_pkg::REG_EPSILON;
  logic [rcu_pkg::CFG_W-1:0]      cfg_data     = '0;

  // Predicted node clock and register copies.
  logic [rcu_pkg::TIME_W-1:0]     st_time  = '0;
  logic [OFF_W-1:0]               st_off [PROCS] = '{default: '0};
  logic [PROCS-1:0]               st_valid = '0;
  logic [rcu_pkg::COUNT_W-1:0]    st_count = '0;
  logic [rcu_pkg::EPS_W-1:0]      cfg_eps  = rcu_pkg::EPSILON_RESET;
  logic [rcu_pkg::OWN_W-1:0]      cfg_own  = rcu_pkg::OWN_RESET;

  rcu_pkg::result_t      expected_clocks [$];
  int                    errors       = 0;
  int                    cycles       = 0;
  int                    hold_asks    = 0;
  int                    hold_seen    = 0;
  int                    stall_left   = 0;
  logic                  rcv_stall_on = 1'b1;
  bit                    src_gap_on   = 1'b1;

  replay_clock_update uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [rcu_pkg::COUNT_W-1:0] bump(
      input logic [rcu_pkg::COUNT_W-1:0] c);
    return (c == rcu_pkg::COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // An offset that is not valid, or that reaches epsilon, comes back as epsilon.
  function automatic logic [63:0] shifted_offset(input logic [rcu_pkg::TIME_W-1:0] t,
                                                 input logic [rcu_pkg::TIME_W-1:0] nt,
                                                 input logic [OFF_W-1:0] off,
                                                 input logic vld);
    logic [rcu_pkg::TIME_W-1:0] d;
    logic [63:0]                v;
    if (!vld) return 64'(cfg_eps);
    d = nt - t;
    v = 64'(d) + 64'(off);
    return (v < 64'(cfg_eps)) ? v : 64'(cfg_eps);
  endfunction

  function automatic rcu_pkg::result_t advance_clock(input rcu_pkg::item_t it);
    rcu_pkg::result_t           r;
    logic [rcu_pkg::TIME_W-1:0] nt;
    logic [rcu_pkg::TIME_W-1:0] lag;
    logic [63:0]                own_off;
    logic [63:0]                a;
    logic [63:0]                b;
    logic [63:0]                m;
    logic [OFF_W-1:0]           noff [PROCS];
    logic [PROCS-1:0]           nvalid;
    logic                       node_eq;
    logic                       msg_eq;
    nvalid = '0;
    if (it.cmd == rcu_pkg::CMD_SEND) begin
      nt = (st_time > it.phys_time) ? st_time : it.phys_time;
      lag = nt - it.phys_time;
      own_off = 64'(cfg_eps);
      if (st_valid[cfg_own] && st_off[cfg_own] < cfg_eps) own_off = 64'(st_off[cfg_own]);
      if (nt == st_time && own_off <= 64'(lag)) begin
        st_count = bump(st_count);
      end else begin
        if (nt == st_time) begin
          st_off[cfg_own] = lag[OFF_W-1:0];
        end else begin
          for (int p = 0; p < PROCS; p++) begin
            a = shifted_offset(st_time, nt, st_off[p], st_valid[p]);
            if (a >= 64'(cfg_eps)) begin
              st_valid[p] = 1'b0;
              st_off[p] = '0;
            end else begin
              st_off[p] = a[OFF_W-1:0];
            end
          end
          st_time = nt;
          st_off[cfg_own] = '0;
        end
        st_valid[cfg_own] = 1'b1;
        st_count = '0;
      end
    end else begin
      nt = (st_time > it.msg_time) ? st_time : it.msg_time;
      if (it.phys_time > nt) nt = it.phys_time;
      for (int p = 0; p < PROCS; p++) begin
        a = shifted_offset(st_time, nt, st_off[p], st_valid[p]);
        b = shifted_offset(it.msg_time, nt, it.msg_offset_word[OFF_W*p +: OFF_W],
                           it.msg_valid[p]);
        m = (a < b) ? a : b;
        if (m < 64'(cfg_eps)) begin
          noff[p] = m[OFF_W-1:0];
          nvalid[p] = 1'b1;
        end else begin
          noff[p] = '0;
        end
      end
      node_eq = (st_time == nt) && (st_valid == nvalid);
      msg_eq = (it.msg_time == nt) && (it.msg_valid == nvalid);
      for (int p = 0; p < PROCS; p++) begin
        if (nvalid[p]) begin
          if (st_off[p] != noff[p]) node_eq = 1'b0;
          if (it.msg_offset_word[OFF_W*p +: OFF_W] != noff[p]) msg_eq = 1'b0;
        end
      end
      if (node_eq && msg_eq) begin
        st_count = bump((st_count > it.msg_count) ? st_count : it.msg_count);
      end else if (node_eq) begin
        st_count = bump(st_count);
      end else if (msg_eq) begin
        st_count = bump(it.msg_count);
      end else begin
        st_count = '0;
      end
      st_time = nt;
      for (int p = 0; p < PROCS; p++) st_off[p] = noff[p];
      st_valid = nvalid;
      st_off[cfg_own] = '0;
      st_valid[cfg_own] = 1'b1;
    end
    r.clock_time = st_time;
    r.clock_valid = st_valid;
    r.clock_count = st_count;
    r.clock_offset_word = '0;
    for (int p = 0; p < PROCS; p++) begin
      r.clock_offset_word[OFF_W*p +: OFF_W] = st_valid[p] ? st_off[p] : '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : check_clocks
    rcu_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_clocks.size() == 0) begin
        $display("%0t unexpected transfer: expected none, actual %h", $time, result);
        errors++;
      end else begin
        want = expected_clocks.pop_front();
        if (result.clock_time !== want.clock_time) begin
          $display("%0t clock_time expected %h actual %h", $time,
                   want.clock_time, result.clock_time);
          errors++;
        end
        if (result.clock_valid !== want.clock_valid) begin
          $display("%0t clock_valid expected %h actual %h", $time,
                   want.clock_valid, result.clock_valid);
          errors++;
        end
        if (result.clock_offset_word !== want.clock_offset_word) begin
          $display("%0t clock_offset_word expected %h actual %h", $time,
                   want.clock_offset_word, result.clock_offset_word);
          errors++;
        end
        if (result.clock_count !== want.clock_count) begin
          $display("%0t clock_count expected %h actual %h", $time,
                   want.clock_count, result.clock_count);
          errors++;
        end
      end
    end
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (rcv_stall_on && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic send_event(input rcu_pkg::item_t it);
    int gap;
    int r;
    gap = 0;
    if (src_gap_on) begin
      r = $urandom_range(0, 99);
      if (r >= 95) begin
        gap = $urandom_range(10, 30);
      end else if (r >= 70) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_clocks.push_back(advance_clock(it));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (expected_clocks.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input rcu_pkg::cfg_reg_t idx,
                           input logic [rcu_pkg::CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rcu_pkg::REG_EPSILON) begin
      cfg_eps = val[rcu_pkg::EPS_W-1:0];
    end else begin
      cfg_own = val[rcu_pkg::OWN_W-1:0];
    end
  endtask

  function automatic rcu_pkg::item_t noise_item();
    rcu_pkg::item_t it;
    it.cmd = 1'($urandom);
    it.phys_time = $urandom;
    it.msg_time = $urandom;
    it.msg_valid = rcu_pkg::VALID_W'($urandom);
    it.msg_offset_word = {$urandom, $urandom};
    it.msg_count = rcu_pkg::COUNT_W'($urandom);
    return it;
  endfunction

  function automatic logic [rcu_pkg::TIME_W-1:0] near_time();
    int unsigned span;
    int unsigned step;
    span = (cfg_eps < 40) ? int'(cfg_eps) + 3 : 40;
    if ($urandom_range(0, 99) < 4) begin
      step = $urandom_range(0, int'(cfg_eps) + 8);
    end else begin
      step = $urandom_range(0, span);
    end
    if ($urandom_range(0, 3) == 0 && st_time >= step) return st_time - step;
    if (st_time > 32'hFFFF_FFFF - step) return st_time;
    return st_time + step;
  endfunction

  function automatic logic [OFF_W-1:0] near_offset();
    if ($urandom_range(0, 9) == 0) return OFF_W'($urandom);
    if (cfg_eps <= 64) return OFF_W'($urandom_range(0, int'(cfg_eps) + 1));
    return OFF_W'($urandom_range(0, 60));
  endfunction

  // A message built from the node's own clock: an exact copy, one that is
  // ahead in time with zero offsets, or one that is behind with a subset of
  // the node's processes.
  function automatic rcu_pkg::item_t echo_msg(input int kind);
    rcu_pkg::item_t it;
    int unsigned    d;
    it = noise_item();
    it.cmd = rcu_pkg::CMD_RECEIVE;
    it.msg_time = st_time;
    it.msg_valid = st_valid;
    it.phys_time = (st_time > 8) ? st_time - $urandom_range(0, 8) : st_time;
    it.msg_count = ($urandom_range(0, 3) == 0) ? rcu_pkg::COUNT_MAX :
                   rcu_pkg::COUNT_W'($urandom_range(0, 40));
    for (int p = 0; p < PROCS; p++) begin
      it.msg_offset_word[OFF_W*p +: OFF_W] =
        st_valid[p] ? st_off[p] : ($urandom_range(0, 1) ? '0 : OFF_W'($urandom));
    end
    d = $urandom_range(1, 20);
    if (kind == 1) begin
      if (st_time <= 32'hFFFF_FF00) it.msg_time = st_time + d;
      it.msg_valid = st_valid | rcu_pkg::VALID_W'($urandom);
      it.msg_offset_word = '0;
    end else if (kind == 2) begin
      if (st_time >= d) it.msg_time = st_time - d;
      it.msg_valid = st_valid & rcu_pkg::VALID_W'($urandom);
    end
    return it;
  endfunction

  function automatic rcu_pkg::item_t rand_item();
    rcu_pkg::item_t it;
    int             r;
    r = $urandom_range(0, 99);
    it = noise_item();
    if (r < 5) return it;
    if (r < 35) begin
      it.cmd = rcu_pkg::CMD_SEND;
      it.phys_time = near_time();
      return it;
    end
    if (r < 55) return echo_msg($urandom_range(0, 2));
    it.cmd = rcu_pkg::CMD_RECEIVE;
    it.phys_time = near_time();
    it.msg_time = near_time();
    for (int p = 0; p < PROCS; p++) it.msg_offset_word[OFF_W*p +: OFF_W] = near_offset();
    it.msg_count = ($urandom_range(0, 9) == 0) ? rcu_pkg::COUNT_MAX :
                   rcu_pkg::COUNT_W'($urandom_range(0, 20));
    return it;
  endfunction

  task automatic send_local_event(input logic [rcu_pkg::TIME_W-1:0] phys);
    rcu_pkg::item_t it;
    it = noise_item();
    it.cmd = rcu_pkg::CMD_SEND;
    it.phys_time = phys;
    send_event(it);
  endtask

  task automatic test_send_rules();
    send_local_event(32'd0);
    send_local_event(32'd0);
    send_local_event(32'd100);
    send_local_event(32'd50);
    send_local_event(32'd100);
    send_local_event(32'd130);
  endtask

  task automatic test_receive_merge();
    rcu_pkg::item_t it;
    it = echo_msg(0);
    it.msg_count = rcu_pkg::COUNT_MAX;
    send_event(it);
    it = echo_msg(0);
    it.msg_count = rcu_pkg::COUNT_MAX;
    send_event(it);
    it = '0;
    it.cmd = rcu_pkg::CMD_RECEIVE;
    send_event(it);
    it = noise_item();
    it.cmd = rcu_pkg::CMD_RECEIVE;
    it.phys_time = st_time;
    it.msg_time = st_time;
    it.msg_valid = '1;
    it.msg_offset_word = '1;
    it.msg_count = rcu_pkg::COUNT_MAX;
    send_event(it);
    send_event(echo_msg(1));
    send_event(echo_msg(2));
    it = noise_item();
    it.cmd = rcu_pkg::CMD_RECEIVE;
    it.phys_time = st_time;
    it.msg_time = st_time + 3;
    it.msg_valid = '0;
    send_event(it);
  endtask

  task automatic test_epsilon_edges();
    rcu_pkg::item_t it;
    write_reg(rcu_pkg::REG_EPSILON, 16'd1);
    send_local_event(st_time);
    send_local_event(st_time + 1);
    send_event(echo_msg(0));
    // Offsets stored under a large epsilon outlive a later, smaller one.
    write_reg(rcu_pkg::REG_EPSILON, 16'hFFFF);
    it = noise_item();
    it.cmd = rcu_pkg::CMD_RECEIVE;
    it.phys_time = st_time;
    it.msg_time = st_time;
    it.msg_valid = 4'b1110;
    it.msg_offset_word = {4{16'd5000}};
    it.msg_count = '0;
    send_event(it);
    write_reg(rcu_pkg::REG_EPSILON, 16'd100);
    send_local_event(st_time);
    send_local_event(st_time + 1);
    write_reg(rcu_pkg::REG_EPSILON, 16'd0);
    send_local_event(st_time + 5);
    send_event(echo_msg(0));
    send_local_event(st_time);
    write_reg(rcu_pkg::REG_EPSILON, 16'hFFFF);
  endtask

  task automatic test_own_process();
    write_reg(rcu_pkg::REG_OWN_PROCESS, 16'd3);
    send_local_event(st_time + 2);
    send_event(echo_msg(2));
    write_reg(rcu_pkg::REG_OWN_PROCESS, 16'd2);
    send_local_event(st_time);
    write_reg(rcu_pkg::REG_OWN_PROCESS, 16'd1);
    send_event(echo_msg(1));
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // block fills and stalls its input.
  task automatic test_backpressure();
    src_gap_on = 1'b0;
    hold_asks <= hold_asks + 1;
    repeat (25) send_event(rand_item());
    src_gap_on = 1'b1;
  endtask

  task automatic run_phase(input logic [rcu_pkg::EPS_W-1:0] eps,
                           input logic [rcu_pkg::OWN_W-1:0] own,
                           input int n, input bit quiet);
    write_reg(rcu_pkg::REG_EPSILON, rcu_pkg::CFG_W'(eps));
    write_reg(rcu_pkg::REG_OWN_PROCESS, rcu_pkg::CFG_W'(own));
    src_gap_on = !quiet;
    rcv_stall_on <= !quiet;
    repeat (n) send_event(rand_item());
  endtask

  task automatic test_random();
    run_phase(16'hFFFF, 2'd0, 70, 1'b0);
    run_phase(16'd1, 2'd3, 60, 1'b0);
    run_phase(rcu_pkg::EPS_W'($urandom_range(2, 40)),
              rcu_pkg::OWN_W'($urandom_range(0, 3)), 70, 1'b1);
    run_phase(rcu_pkg::EPS_W'($urandom_range(41, 65535)),
              rcu_pkg::OWN_W'($urandom_range(0, 3)), 70, 1'b0);
    run_phase(16'd300, 2'd2, 70, 1'b0);
    run_phase(16'hFFFE, 2'd1, 70, 1'b0);
    src_gap_on = 1'b1;
    rcv_stall_on <= 1'b1;
  endtask

  // Time stops at its ceiling, so this runs last.
  task automatic test_time_ceiling();
    rcu_pkg::item_t it;
    send_local_event(32'hFFFF_FFFF);
    it.cmd = rcu_pkg::CMD_RECEIVE;
    it.phys_time = '1;
    it.msg_time = '1;
    it.msg_valid = '1;
    it.msg_offset_word = '1;
    it.msg_count = rcu_pkg::COUNT_MAX;
    send_event(it);
    send_local_event(32'd0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_send_rules();
    test_receive_merge();
    test_epsilon_edges();
    test_own_process();
    test_backpressure();
    test_random();
    test_time_ceiling();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
